@@ design/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame parser, the queue and the
// result stage.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  localparam int unsigned LenW = 17;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [LenW-1:0] MaxPayloadRst = 17'h10000;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhExt16,
    PhExt64,
    PhMask,
    PhData
  } phase_e;

  typedef enum logic [1:0] {
    StData,
    StEmpty,
    StClose,
    StLong
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        last;
    logic [3:0]  opcode;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/wsd_if.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer channels
// Valid/ready channels for the raw byte stream and for the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] payload_byte;
  logic       frame_last;
  logic [3:0] frame_opcode;

  modport source (output valid, output status, output payload_byte,
                  output frame_last, output frame_opcode, input ready);
  modport sink (input valid, input status, input payload_byte,
                input frame_last, input frame_opcode, output ready);
endinterface

`default_nettype wire

@@ design/wsd_parser.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Front part: takes one byte per cycle while the queue is not full, walks the
// frame header, classifies every byte and pushes at most one command per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser import wsd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [LenW-1:0] cfg_wdata_i,
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      in_byte_i,
  output logic                 in_ready_o,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  phase_e            phase_q, phase_d;
  logic [3:0]        opcode_q, opcode_d;
  logic              mask_q, mask_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              over_q, over_d;
  logic [2:0]        hdr_cnt_q, hdr_cnt_d;
  logic [31:0]       key_q, key_d;
  logic [LenW-1:0]   pay_cnt_q, pay_cnt_d;
  logic              halted_q, halted_d;
  logic [LenW-1:0]   max_q;

  logic              acc;
  logic              is_ext16, is_ext64;
  logic [LenW-1:0]   len_shift;
  logic              over_shift;
  logic              ext_last;
  logic [LenW-1:0]   len_chk;
  logic              over_chk;
  logic              too_long;
  logic [LenW-1:0]   start_len;
  logic              zero_len;
  logic [LenW-1:0]   pay_cnt_inc;
  logic              data_last;
  logic [7:0]        key_byte;

  assign in_ready_o = !q_full_i;
  assign acc = in_valid_i && in_ready_o;

  assign is_ext16 = in_byte_i[6:0] == Len7Ext16;
  assign is_ext64 = in_byte_i[6:0] == Len7Ext64;
  assign len_shift = {len_q[LenW-9:0], in_byte_i};
  assign over_shift = over_q || (|len_q[LenW-1:LenW-8]);
  assign ext_last = ((phase_q == PhExt16) && (hdr_cnt_q == 3'd1)) ||
                    ((phase_q == PhExt64) && (hdr_cnt_q == 3'd7));
  assign len_chk = (phase_q == PhHdr1) ? {{(LenW-7){1'b0}}, in_byte_i[6:0]} : len_shift;
  assign over_chk = (phase_q == PhHdr1) ? 1'b0 : over_shift;
  assign too_long = over_chk || (len_chk > max_q);
  assign start_len = (phase_q == PhMask) ? len_q : len_chk;
  assign zero_len = start_len == '0;
  assign pay_cnt_inc = pay_cnt_q + 1'b1;
  assign data_last = pay_cnt_inc >= len_q;
  assign key_byte = mask_q ? key_q[8*(3 - pay_cnt_q[1:0]) +: 8] : 8'h00;

  always_comb begin
    phase_d   = phase_q;
    opcode_d  = opcode_q;
    mask_d    = mask_q;
    len_d     = len_q;
    over_d    = over_q;
    hdr_cnt_d = hdr_cnt_q;
    key_d     = key_q;
    pay_cnt_d = pay_cnt_q;
    halted_d  = halted_q;
    if (acc && !halted_q) begin
      unique case (phase_q)
        PhHdr0: begin
          opcode_d = in_byte_i[3:0];
          phase_d  = PhHdr1;
        end
        PhHdr1: begin
          if (opcode_q == OpClose) begin
            halted_d = 1'b1;
          end else begin
            mask_d    = in_byte_i[7];
            len_d     = '0;
            over_d    = 1'b0;
            hdr_cnt_d = '0;
            if (is_ext16) begin
              phase_d = PhExt16;
            end else if (is_ext64) begin
              phase_d = PhExt64;
            end else begin
              len_d = len_chk;
              if (too_long) begin
                halted_d = 1'b1;
              end else if (in_byte_i[7]) begin
                key_d   = '0;
                phase_d = PhMask;
              end else begin
                pay_cnt_d = '0;
                phase_d   = zero_len ? PhHdr0 : PhData;
              end
            end
          end
        end
        PhExt16, PhExt64: begin
          len_d     = len_shift;
          over_d    = over_shift;
          hdr_cnt_d = hdr_cnt_q + 3'd1;
          if (ext_last) begin
            hdr_cnt_d = '0;
            if (too_long) begin
              halted_d = 1'b1;
            end else if (mask_q) begin
              key_d   = '0;
              phase_d = PhMask;
            end else begin
              pay_cnt_d = '0;
              phase_d   = zero_len ? PhHdr0 : PhData;
            end
          end
        end
        PhMask: begin
          key_d     = {key_q[23:0], in_byte_i};
          hdr_cnt_d = hdr_cnt_q + 3'd1;
          if (hdr_cnt_q == 3'd3) begin
            hdr_cnt_d = '0;
            pay_cnt_d = '0;
            phase_d   = zero_len ? PhHdr0 : PhData;
          end
        end
        PhData: begin
          pay_cnt_d = pay_cnt_inc;
          if (data_last) begin
            pay_cnt_d = '0;
            phase_d   = PhHdr0;
          end
        end
        default: begin
          phase_d = PhHdr0;
        end
      endcase
    end
  end

  always_comb begin
    push_o        = 1'b0;
    cmd_o.status  = StData;
    cmd_o.data    = 8'h00;
    cmd_o.key     = 8'h00;
    cmd_o.last    = 1'b0;
    cmd_o.opcode  = opcode_q;
    if (acc && !halted_q) begin
      unique case (phase_q)
        PhHdr0: begin
          push_o = 1'b0;
        end
        PhHdr1: begin
          if (opcode_q == OpClose) begin
            push_o       = 1'b1;
            cmd_o.status = StClose;
          end else if (!is_ext16 && !is_ext64) begin
            if (too_long) begin
              push_o       = 1'b1;
              cmd_o.status = StLong;
            end else if (!in_byte_i[7] && zero_len) begin
              push_o       = 1'b1;
              cmd_o.status = StEmpty;
              cmd_o.last   = 1'b1;
            end
          end
        end
        PhExt16, PhExt64: begin
          if (ext_last) begin
            if (too_long) begin
              push_o       = 1'b1;
              cmd_o.status = StLong;
            end else if (!mask_q && zero_len) begin
              push_o       = 1'b1;
              cmd_o.status = StEmpty;
              cmd_o.last   = 1'b1;
            end
          end
        end
        PhMask: begin
          if ((hdr_cnt_q == 3'd3) && zero_len) begin
            push_o       = 1'b1;
            cmd_o.status = StEmpty;
            cmd_o.last   = 1'b1;
          end
        end
        PhData: begin
          push_o       = 1'b1;
          cmd_o.status = StData;
          cmd_o.data   = in_byte_i;
          cmd_o.key    = key_byte;
          cmd_o.last   = data_last;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHdr0;
      opcode_q  <= '0;
      mask_q    <= 1'b0;
      len_q     <= '0;
      over_q    <= 1'b0;
      hdr_cnt_q <= '0;
      key_q     <= '0;
      pay_cnt_q <= '0;
      halted_q  <= 1'b0;
      max_q     <= MaxPayloadRst;
    end else begin
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      mask_q    <= mask_d;
      len_q     <= len_d;
      over_q    <= over_d;
      hdr_cnt_q <= hdr_cnt_d;
      key_q     <= key_d;
      pay_cnt_q <= pay_cnt_d;
      halted_q  <= halted_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/wsd_queue.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer command queue
// Short first-in first-out buffer between the parser and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_queue import wsd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output cmd_t      cmd_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o  = cnt_q == QueueCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/wsd_emit.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer result stage
// Back part: takes commands from the queue, unmasks payload bytes and holds
// each result item in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_emit import wsd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       pop_o,
  wsd_out_if.source  res_o
);

  logic       valid_q;
  status_e    status_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic [3:0] opcode_q;

  assign pop_o = q_valid_i && (!valid_q || res_o.ready);

  assign res_o.valid        = valid_q;
  assign res_o.status       = status_q;
  assign res_o.payload_byte = byte_q;
  assign res_o.frame_last   = last_q;
  assign res_o.frame_opcode = opcode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= q_cmd_i.status;
      byte_q   <= (q_cmd_i.status == StData) ? (q_cmd_i.data ^ q_cmd_i.key) : 8'h00;
      last_q   <= q_cmd_i.last;
      opcode_q <= q_cmd_i.opcode;
    end
  end

endmodule

`default_nettype wire

@@ design/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Top level: parser, command queue and result stage.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle and returns the decoded
// payload bytes, unmasked, with the last byte of each frame marked; a frame
// without payload gives one empty-frame item, and a close frame or a frame
// longer than max_payload gives one error item, after which every byte is
// dropped until reset. A byte is accepted in every cycle in which the
// two-entry command queue has room, so a continuous stream runs at one byte
// per cycle while results are taken; a result item is written into the queue
// at the edge that accepts its byte and moves into the output register when
// the result stage pops it from the queue.
`default_nettype none

module websocket_frame_deframer import wsd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [LenW-1:0] cfg_wdata_i,
  wsd_in_if.sink               byte_i,
  wsd_out_if.source            result_o
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic pop;
  cmd_t q_cmd;

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (byte_i.valid),
    .in_byte_i   (byte_i.in_byte),
    .in_ready_o  (byte_i.ready),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  wsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (q_cmd)
  );

  wsd_emit u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .res_o     (result_o)
  );

endmodule

`default_nettype wire

@@ design/wsd_checker.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_checker import wsd_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] status_i,
  input wire logic [7:0] payload_byte_i,
  input wire logic       frame_last_i
);

  logic err_item;

  assign err_item = out_valid_i && ((status_i == StClose) || (status_i == StLong));

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result item dropped while stalled.");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != StData) |-> payload_byte_i == 8'h00)
    else $error("Non-payload item carries a nonzero byte.");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == StEmpty) |-> frame_last_i)
    else $error("Empty-frame item without frame_last.");

  a_err_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_item |-> !frame_last_i)
    else $error("Error item marked as frame end.");

  a_quiet_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_item && out_ready_i |=> !out_valid_i)
    else $error("Result item after an error item.");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .status_i       (result_o.status),
  .payload_byte_i (result_o.payload_byte),
  .frame_last_i   (result_o.frame_last)
);

`default_nettype wire
